// ===== design/ptsd_pkg.sv =====
`default_nettype none

package ptsd_pkg;

   // Width of the distance field on the result channel.
   localparam int OUT_BITS = 23;

   // Width of the register index on the configuration channel.
   localparam int CSR_INDEX_BITS = 3;

   // Number of entries in the queue between the front and the back.
   localparam int FIFO_DEPTH = 4;

   // Shape selected by the shape_kind register.
   typedef enum logic [1:0] {
      SHAPE_LINE   = 2'd0,
      SHAPE_RECT   = 2'd1,
      SHAPE_CIRCLE = 2'd2,
      SHAPE_MARKER = 2'd3
   } shape_kind_type;

   // Register indexes on the configuration channel.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SHAPE_KIND = 3'd0,
      CSR_ANCHOR_X   = 3'd1,
      CSR_ANCHOR_Y   = 3'd2,
      CSR_SECOND_X   = 3'd3,
      CSR_SECOND_Y   = 3'd4
   } csr_index_type;

   // Fill status of the queue, seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

`default_nettype wire

// ===== design/point_to_shape_distance_unit.sv =====
`default_nettype none

// Distance from a query point to one configured shape (line segment, axis-aligned
// rectangle, circle outline or marker point), returned as unsigned fixed point
// with FRAC_BITS fraction bits, truncated, saturating at the field maximum. A new
// point is taken in every cycle unless a full queue stalls the front; results
// come out in input order. The long division retires one quotient bit per stage,
// the square root one result bit per stage. A short queue sits between the
// classifying front and the arithmetic back, so a stalled result holds the back
// first and the front only once the queue is full. Write the shape registers
// only while no points are in flight; they are read live by both halves.
module point_to_shape_distance_unit #(
   parameter int COORD_BITS = 14,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [COORD_BITS-1:0]                req_query_x,
   input  wire logic [COORD_BITS-1:0]                req_query_y,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [ptsd_pkg::OUT_BITS-1:0]             rsp_distance,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ptsd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [COORD_BITS-1:0]                csr_wdata
);

   localparam int SW = 2 * COORD_BITS + 1;
   localparam int EW = 3 * SW;

   ptsd_pkg::shape_kind_type  kind_ff;
   logic [COORD_BITS-1:0]     anchor_x_ff, anchor_y_ff, second_x_ff, second_y_ff;
   ptsd_pkg::fifo_status_type fifo_status;
   logic                      push_valid, pop;
   logic [2*SW-1:0]           push_sel;
   logic [SW-1:0]             push_div;
   logic [EW-1:0]             head_data;

   // Shape registers; writes are always accepted, unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff     <= ptsd_pkg::SHAPE_LINE;
         anchor_x_ff <= '0;
         anchor_y_ff <= '0;
         second_x_ff <= '0;
         second_y_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            ptsd_pkg::CSR_SHAPE_KIND: kind_ff <= ptsd_pkg::shape_kind_type'(csr_wdata[1:0]);
            ptsd_pkg::CSR_ANCHOR_X:   anchor_x_ff <= csr_wdata;
            ptsd_pkg::CSR_ANCHOR_Y:   anchor_y_ff <= csr_wdata;
            ptsd_pkg::CSR_SECOND_X:   second_x_ff <= csr_wdata;
            ptsd_pkg::CSR_SECOND_Y:   second_y_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Front: differences, products and classification.
   ptsd_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .query_x     (req_query_x),
      .query_y     (req_query_y),
      .shape_kind  (kind_ff),
      .anchor_x    (anchor_x_ff),
      .anchor_y    (anchor_y_ff),
      .second_x    (second_x_ff),
      .second_y    (second_y_ff),
      .fifo_status (fifo_status),
      .push_valid  (push_valid),
      .push_sel    (push_sel),
      .push_div    (push_div)
   );

   // Queue between the two halves.
   ptsd_fifo #(
      .WIDTH (EW),
      .DEPTH (ptsd_pkg::FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_sel, push_div}),
      .pop       (pop),
      .pop_data  (head_data),
      .status    (fifo_status)
   );

   // Back: division, square root and the circle correction.
   ptsd_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .fifo_status  (fifo_status),
      .head_sel     (head_data[EW-1:SW]),
      .head_div     (head_data[SW-1:0]),
      .pop          (pop),
      .shape_kind   (kind_ff),
      .second_x     (second_x_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_distance (rsp_distance)
   );

endmodule

`default_nettype wire

// ===== design/ptsd_fifo.sv =====
`default_nettype none

module ptsd_fifo #(
   parameter int WIDTH = 87,
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   input  wire logic                       pop,
   output logic [WIDTH-1:0]                pop_data,
   output ptsd_pkg::fifo_status_type       status
);

   localparam int PTRW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   // Pointers wrap at the depth, which need not be a power of two.
   assign wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTRW'(1);
   assign rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTRW'(1);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNTW'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ===== design/ptsd_front.sv =====
`default_nettype none

module ptsd_front #(
   parameter  int COORD_BITS = 14,
   localparam int SW         = 2 * COORD_BITS + 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic [COORD_BITS-1:0]      query_x,
   input  wire logic [COORD_BITS-1:0]      query_y,
   input  wire ptsd_pkg::shape_kind_type   shape_kind,
   input  wire logic [COORD_BITS-1:0]      anchor_x,
   input  wire logic [COORD_BITS-1:0]      anchor_y,
   input  wire logic [COORD_BITS-1:0]      second_x,
   input  wire logic [COORD_BITS-1:0]      second_y,
   input  wire ptsd_pkg::fifo_status_type  fifo_status,
   output logic                            push_valid,
   output logic [2*SW-1:0]                 push_sel,
   output logic [SW-1:0]                   push_div
);

   localparam int DW  = COORD_BITS + 1;
   localparam int PW  = 2 * DW;
   localparam int NMW = PW + 1;
   localparam int QW  = 2 * COORD_BITS;

   logic front_en;

   // Magnitude of a coordinate difference; it never reaches -2^COORD_BITS.
   function automatic logic [COORD_BITS-1:0] mag(input logic signed [DW-1:0] v);
      mag = v[DW-1] ? COORD_BITS'(-v) : COORD_BITS'(v);
   endfunction

   // The front stalls only when its last stage cannot hand its beat to the queue.
   logic s6_vld_ff;
   assign front_en   = !(s6_vld_ff && fifo_status.full);
   assign in_ready   = front_en;
   assign push_valid = s6_vld_ff && !fifo_status.full;

   // Stage 1: coordinate differences.
   logic                 s1_vld_ff;
   logic signed [DW-1:0] s1_pax_ff, s1_pay_ff, s1_pbx_ff, s1_pby_ff, s1_dx_ff, s1_dy_ff;
   logic signed [DW-1:0] s1_pax_in, s1_pay_in, s1_pbx_in, s1_pby_in, s1_dx_in, s1_dy_in;

   assign s1_pax_in = $signed({1'b0, query_x})  - $signed({1'b0, anchor_x});
   assign s1_pay_in = $signed({1'b0, query_y})  - $signed({1'b0, anchor_y});
   assign s1_pbx_in = $signed({1'b0, query_x})  - $signed({1'b0, second_x});
   assign s1_pby_in = $signed({1'b0, query_y})  - $signed({1'b0, second_y});
   assign s1_dx_in  = $signed({1'b0, second_x}) - $signed({1'b0, anchor_x});
   assign s1_dy_in  = $signed({1'b0, second_y}) - $signed({1'b0, anchor_y});

   // Stage 2: magnitudes, nearest edge offsets and range tests for the rectangle.
   logic                  s2_vld_ff;
   logic signed [DW-1:0]  s2_pax_ff, s2_pay_ff, s2_pbx_ff, s2_pby_ff, s2_dx_ff, s2_dy_ff;
   logic [COORD_BITS-1:0] s2_ddx_ff, s2_ddy_ff, s2_mn_ff;
   logic                  s2_inx_ff, s2_iny_ff;
   logic [COORD_BITS-1:0] s2_ddx_in, s2_ddy_in, s2_mn_in;
   logic [COORD_BITS-1:0] mag_ax, mag_ay, mag_bx, mag_by;
   logic                  s2_inx_in, s2_iny_in;

   assign mag_ax    = mag(s1_pax_ff);
   assign mag_ay    = mag(s1_pay_ff);
   assign mag_bx    = mag(s1_pbx_ff);
   assign mag_by    = mag(s1_pby_ff);
   assign s2_ddx_in = (mag_ax < mag_bx) ? mag_ax : mag_bx;
   assign s2_ddy_in = (mag_ay < mag_by) ? mag_ay : mag_by;
   assign s2_mn_in  = (s2_ddx_in < s2_ddy_in) ? s2_ddx_in : s2_ddy_in;

   // The query lies between the edges when the differences to them differ in sign.
   assign s2_inx_in =
      (!s1_pax_ff[DW-1] && (s1_pbx_ff[DW-1] || s1_pbx_ff == '0)) ||
      (!s1_pbx_ff[DW-1] && (s1_pax_ff[DW-1] || s1_pax_ff == '0));
   assign s2_iny_in =
      (!s1_pay_ff[DW-1] && (s1_pby_ff[DW-1] || s1_pby_ff == '0)) ||
      (!s1_pby_ff[DW-1] && (s1_pay_ff[DW-1] || s1_pay_ff == '0));

   // Stage 3: all products, side by side.
   logic                 s3_vld_ff;
   logic signed [PW-1:0] s3_aydx_ff, s3_axdy_ff, s3_axdx_ff, s3_aydy_ff;
   logic signed [PW-1:0] s3_dxdx_ff, s3_dydy_ff, s3_axax_ff, s3_ayay_ff;
   logic signed [PW-1:0] s3_bxbx_ff, s3_byby_ff;
   logic [QW-1:0]        s3_qx_ff, s3_qy_ff, s3_qmn_ff;
   logic                 s3_inx_ff, s3_iny_ff;

   // Stage 4: sums of products.
   logic                  s4_vld_ff;
   logic signed [NMW-1:0] s4_num_ff, s4_cross_ff, s4_num_in, s4_cross_in;
   logic [SW-1:0]         s4_d0_ff, s4_e1_ff, s4_e2_ff, s4_rect_ff;
   logic [SW-1:0]         s4_d0_in, s4_e1_in, s4_e2_in, s4_rect_in;

   assign s4_num_in   = $signed({s3_axdx_ff[PW-1], s3_axdx_ff})
                      + $signed({s3_aydy_ff[PW-1], s3_aydy_ff});
   assign s4_cross_in = $signed({s3_aydx_ff[PW-1], s3_aydx_ff})
                      - $signed({s3_axdy_ff[PW-1], s3_axdy_ff});
   assign s4_d0_in    = {1'b0, s3_dxdx_ff[QW-1:0]} + {1'b0, s3_dydy_ff[QW-1:0]};
   assign s4_e1_in    = {1'b0, s3_axax_ff[QW-1:0]} + {1'b0, s3_ayay_ff[QW-1:0]};
   assign s4_e2_in    = {1'b0, s3_bxbx_ff[QW-1:0]} + {1'b0, s3_byby_ff[QW-1:0]};

   // Rectangle: inside, beside an edge, or off a corner.
   always_comb begin
      priority if (s3_inx_ff && s3_iny_ff) begin
         s4_rect_in = {1'b0, s3_qmn_ff};
      end else if (s3_inx_ff) begin
         s4_rect_in = {1'b0, s3_qy_ff};
      end else if (s3_iny_ff) begin
         s4_rect_in = {1'b0, s3_qx_ff};
      end else begin
         s4_rect_in = {1'b0, s3_qx_ff} + {1'b0, s3_qy_ff};
      end
   end

   // Stage 5: classify the beat and pick the squared distance.
   logic          s5_vld_ff;
   logic          s5_perp_ff, s5_perp_in;
   logic [SW-1:0] s5_det_ff, s5_det_in, s5_d2_ff, s5_d2_in, s5_d0_ff;
   logic          num_fits;

   assign num_fits   = !s4_num_ff[NMW-1] && (s4_num_ff <= $signed({2'b00, s4_d0_ff}));
   assign s5_perp_in = (shape_kind == ptsd_pkg::SHAPE_LINE) && (s4_d0_ff != '0) && num_fits;
   assign s5_det_in  = s4_cross_ff[NMW-1] ? SW'(-s4_cross_ff) : SW'(s4_cross_ff);

   always_comb begin
      unique case (shape_kind)
         ptsd_pkg::SHAPE_LINE: begin
            if (s4_d0_ff == '0) begin
               s5_d2_in = s4_e1_ff;
            end else begin
               s5_d2_in = (s4_e1_ff < s4_e2_ff) ? s4_e1_ff : s4_e2_ff;
            end
         end
         ptsd_pkg::SHAPE_RECT:   s5_d2_in = s4_rect_ff;
         ptsd_pkg::SHAPE_CIRCLE: s5_d2_in = s4_e1_ff;
         ptsd_pkg::SHAPE_MARKER: s5_d2_in = s4_e1_ff;
      endcase
   end

   // Stage 6: the dividend base and the divisor for the back.
   logic [2*SW-1:0] s6_sel_ff, s6_sel_in, det_sq;
   logic [SW-1:0]   s6_div_ff, s6_div_in;

   assign det_sq    = (2*SW)'(s5_det_ff) * (2*SW)'(s5_det_ff);
   assign s6_sel_in = s5_perp_ff ? det_sq : (2*SW)'(s5_d2_ff);
   assign s6_div_in = s5_perp_ff ? s5_d0_ff : SW'(1);

   // Valid bits of the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else if (front_en) begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
      end
   end

   // Payload of the stages.
   always_ff @(posedge clock) begin
      if (front_en) begin
         s1_pax_ff   <= s1_pax_in;
         s1_pay_ff   <= s1_pay_in;
         s1_pbx_ff   <= s1_pbx_in;
         s1_pby_ff   <= s1_pby_in;
         s1_dx_ff    <= s1_dx_in;
         s1_dy_ff    <= s1_dy_in;

         s2_pax_ff   <= s1_pax_ff;
         s2_pay_ff   <= s1_pay_ff;
         s2_pbx_ff   <= s1_pbx_ff;
         s2_pby_ff   <= s1_pby_ff;
         s2_dx_ff    <= s1_dx_ff;
         s2_dy_ff    <= s1_dy_ff;
         s2_ddx_ff   <= s2_ddx_in;
         s2_ddy_ff   <= s2_ddy_in;
         s2_mn_ff    <= s2_mn_in;
         s2_inx_ff   <= s2_inx_in;
         s2_iny_ff   <= s2_iny_in;

         s3_aydx_ff  <= s2_pay_ff * s2_dx_ff;
         s3_axdy_ff  <= s2_pax_ff * s2_dy_ff;
         s3_axdx_ff  <= s2_pax_ff * s2_dx_ff;
         s3_aydy_ff  <= s2_pay_ff * s2_dy_ff;
         s3_dxdx_ff  <= s2_dx_ff * s2_dx_ff;
         s3_dydy_ff  <= s2_dy_ff * s2_dy_ff;
         s3_axax_ff  <= s2_pax_ff * s2_pax_ff;
         s3_ayay_ff  <= s2_pay_ff * s2_pay_ff;
         s3_bxbx_ff  <= s2_pbx_ff * s2_pbx_ff;
         s3_byby_ff  <= s2_pby_ff * s2_pby_ff;
         s3_qx_ff    <= QW'(s2_ddx_ff) * QW'(s2_ddx_ff);
         s3_qy_ff    <= QW'(s2_ddy_ff) * QW'(s2_ddy_ff);
         s3_qmn_ff   <= QW'(s2_mn_ff) * QW'(s2_mn_ff);
         s3_inx_ff   <= s2_inx_ff;
         s3_iny_ff   <= s2_iny_ff;

         s4_num_ff   <= s4_num_in;
         s4_cross_ff <= s4_cross_in;
         s4_d0_ff    <= s4_d0_in;
         s4_e1_ff    <= s4_e1_in;
         s4_e2_ff    <= s4_e2_in;
         s4_rect_ff  <= s4_rect_in;

         s5_perp_ff  <= s5_perp_in;
         s5_det_ff   <= s5_det_in;
         s5_d2_ff    <= s5_d2_in;
         s5_d0_ff    <= s4_d0_ff;

         s6_sel_ff   <= s6_sel_in;
         s6_div_ff   <= s6_div_in;
      end
   end

   assign push_sel = s6_sel_ff;
   assign push_div = s6_div_ff;

endmodule

`default_nettype wire

// ===== design/ptsd_back.sv =====
`default_nettype none

module ptsd_back #(
   parameter  int COORD_BITS = 14,
   parameter  int FRAC_BITS  = 8,
   localparam int SW         = 2 * COORD_BITS + 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ptsd_pkg::fifo_status_type     fifo_status,
   input  wire logic [2*SW-1:0]               head_sel,
   input  wire logic [SW-1:0]                 head_div,
   output logic                               pop,
   input  wire ptsd_pkg::shape_kind_type      shape_kind,
   input  wire logic [COORD_BITS-1:0]         second_x,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ptsd_pkg::OUT_BITS-1:0]      rsp_distance
);

   localparam int NW = 2 * SW + 2 * FRAC_BITS;
   localparam int Q  = SW + 2 * FRAC_BITS;
   localparam int R  = COORD_BITS + FRAC_BITS + 1;
   localparam int XW = (R > ptsd_pkg::OUT_BITS) ? R : ptsd_pkg::OUT_BITS;

   logic back_en;
   logic rsp_valid_ff;
   logic [ptsd_pkg::OUT_BITS-1:0] rsp_distance_ff, rsp_distance_in;

   // The whole back moves whenever the output register is free or being emptied.
   assign back_en = !rsp_valid_ff || rsp_ready;
   assign pop     = back_en && !fifo_status.empty;

   // Long division, one quotient bit per stage. The low dividend bits shift out
   // of the top of lq while quotient bits shift in at the bottom.
   logic [NW-1:0] head_num;
   assign head_num = NW'(head_sel) << (2 * FRAC_BITS);

   logic [SW-1:0] dv_rem_ff [0:Q-1];
   logic [Q-1:0]  dv_lq_ff  [0:Q-1];
   logic [SW-1:0] dv_div_ff [0:Q-1];
   logic          dv_vld_ff [0:Q-1];
   logic [SW-1:0] dv_rem_x  [0:Q-1];
   logic [Q-1:0]  dv_lq_x   [0:Q-1];
   logic [SW-1:0] dv_div_x  [0:Q-1];
   logic          dv_vld_x  [0:Q-1];
   logic [SW:0]   dv_trial  [0:Q-1];
   logic          dv_ge     [0:Q-1];
   logic [SW-1:0] dv_rem_in [0:Q-1];
   logic [Q-1:0]  dv_lq_in  [0:Q-1];

   always_comb begin
      dv_rem_x[0] = head_num[NW-1:Q];
      dv_lq_x[0]  = head_num[Q-1:0];
      dv_div_x[0] = head_div;
      dv_vld_x[0] = !fifo_status.empty;
      for (int i = 1; i < Q; i++) begin
         dv_rem_x[i] = dv_rem_ff[i-1];
         dv_lq_x[i]  = dv_lq_ff[i-1];
         dv_div_x[i] = dv_div_ff[i-1];
         dv_vld_x[i] = dv_vld_ff[i-1];
      end
   end

   always_comb begin
      for (int i = 0; i < Q; i++) begin
         dv_trial[i]  = {dv_rem_x[i], dv_lq_x[i][Q-1]};
         dv_ge[i]     = (dv_trial[i] >= {1'b0, dv_div_x[i]});
         dv_rem_in[i] = dv_ge[i] ? SW'(dv_trial[i] - {1'b0, dv_div_x[i]})
                                 : dv_trial[i][SW-1:0];
         dv_lq_in[i]  = {dv_lq_x[i][Q-2:0], dv_ge[i]};
      end
   end

   // Square root, one result bit per stage; the final remainder flags an exact root.
   logic [R:0]     sq_rem_ff  [0:R-1];
   logic [R-1:0]   sq_root_ff [0:R-1];
   logic [2*R-1:0] sq_x_ff    [0:R-1];
   logic           sq_vld_ff  [0:R-1];
   logic [R:0]     sq_rem_x   [0:R-1];
   logic [R-1:0]   sq_root_x  [0:R-1];
   logic [2*R-1:0] sq_x_x     [0:R-1];
   logic           sq_vld_x   [0:R-1];
   logic [R+2:0]   sq_cur     [0:R-1];
   logic [R+2:0]   sq_trial   [0:R-1];
   logic           sq_ge      [0:R-1];
   logic [R:0]     sq_rem_in  [0:R-1];
   logic [R-1:0]   sq_root_in [0:R-1];
   logic [2*R-1:0] sq_x_in    [0:R-1];

   always_comb begin
      sq_rem_x[0]  = '0;
      sq_root_x[0] = '0;
      sq_x_x[0]    = {1'b0, dv_lq_ff[Q-1]};
      sq_vld_x[0]  = dv_vld_ff[Q-1];
      for (int j = 1; j < R; j++) begin
         sq_rem_x[j]  = sq_rem_ff[j-1];
         sq_root_x[j] = sq_root_ff[j-1];
         sq_x_x[j]    = sq_x_ff[j-1];
         sq_vld_x[j]  = sq_vld_ff[j-1];
      end
   end

   always_comb begin
      for (int j = 0; j < R; j++) begin
         sq_cur[j]     = {sq_rem_x[j], sq_x_x[j][2*R-1:2*R-2]};
         sq_trial[j]   = {1'b0, sq_root_x[j], 2'b01};
         sq_ge[j]      = (sq_cur[j] >= sq_trial[j]);
         sq_rem_in[j]  = sq_ge[j] ? (R+1)'(sq_cur[j] - sq_trial[j]) : sq_cur[j][R:0];
         sq_root_in[j] = {sq_root_x[j][R-2:0], sq_ge[j]};
         sq_x_in[j]    = {sq_x_x[j][2*R-3:0], 2'b00};
      end
   end

   // Circle outline: distance from the scaled radius, rounding the root up
   // inside the circle unless it is exact. Then saturate to the field width.
   logic [R-1:0]  root_fin, radius_fx, dist_raw;
   logic          root_exact;
   logic [XW-1:0] dist_ext;

   assign root_fin   = sq_root_ff[R-1];
   assign root_exact = (sq_rem_ff[R-1] == '0);
   assign radius_fx  = R'(second_x) << FRAC_BITS;

   always_comb begin
      if (shape_kind != ptsd_pkg::SHAPE_CIRCLE) begin
         dist_raw = root_fin;
      end else if (root_fin >= radius_fx) begin
         dist_raw = root_fin - radius_fx;
      end else if (root_exact) begin
         dist_raw = radius_fx - root_fin;
      end else begin
         dist_raw = radius_fx - root_fin - R'(1);
      end
   end

   assign dist_ext        = XW'(dist_raw);
   assign rsp_distance_in = (dist_ext > XW'({ptsd_pkg::OUT_BITS{1'b1}}))
                          ? {ptsd_pkg::OUT_BITS{1'b1}}
                          : dist_ext[ptsd_pkg::OUT_BITS-1:0];

   // Valid bits of all stages and of the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Q; i++) begin
            dv_vld_ff[i] <= 1'b0;
         end
         for (int j = 0; j < R; j++) begin
            sq_vld_ff[j] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (back_en) begin
         for (int i = 0; i < Q; i++) begin
            dv_vld_ff[i] <= dv_vld_x[i];
         end
         for (int j = 0; j < R; j++) begin
            sq_vld_ff[j] <= sq_vld_x[j];
         end
         rsp_valid_ff <= sq_vld_ff[R-1];
      end
   end

   // Payload of all stages and of the output register.
   always_ff @(posedge clock) begin
      if (back_en) begin
         for (int i = 0; i < Q; i++) begin
            dv_rem_ff[i] <= dv_rem_in[i];
            dv_lq_ff[i]  <= dv_lq_in[i];
            dv_div_ff[i] <= dv_div_x[i];
         end
         for (int j = 0; j < R; j++) begin
            sq_rem_ff[j]  <= sq_rem_in[j];
            sq_root_ff[j] <= sq_root_in[j];
            sq_x_ff[j]    <= sq_x_in[j];
         end
         rsp_distance_ff <= rsp_distance_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;

endmodule

`default_nettype wire

// ===== design/ptsd_checker.sv =====
`default_nettype none

module ptsd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [ptsd_pkg::OUT_BITS-1:0] rsp_distance
);

   logic [15:0] pend_ff, pend_in;

   // Points taken but not yet answered.
   assign pend_in = pend_ff + 16'(req_valid && req_ready) - 16'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Reset empties the result side and opens the request side.
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result pending or request side closed after reset");

   // No result beat without a point still owed one.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 16'd0)
      else $error("result beat with no outstanding point");

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance))
      else $error("stalled result beat changed");

endmodule

bind point_to_shape_distance_unit ptsd_checker u_ptsd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_distance (rsp_distance)
);

`default_nettype wire
